// ===== rtl/apr_pkg.sv =====
// Shared types and constants for the aging page replacement core.
// Holds the sequencer state type, the frame store write controls and the age codes.
// No dependencies.
package apr_pkg;

  // Default sizes, handed down as parameter defaults from the top level.
  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 20;

  // Fixed field widths of the ports.
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned AGE_W       = 8;
  localparam int unsigned FRM_OUT_W   = 4;
  localparam int unsigned TOTAL_W     = 32;

  // Reset value of the frames-in-use register.
  localparam logic [CFG_W-1:0] CFG_FRAMES_RST = 5'd16;

  // Age codes.
  localparam logic [AGE_W-1:0] AGE_FULL = 8'hFF;
  localparam logic [AGE_W-1:0] AGE_NEW  = 8'h80;
  localparam logic [AGE_W-1:0] AGE_TOP  = 8'h80;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT_RD,
    ST_HIT_WR,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } apr_state_t;

  // Write strobes into the frame store.
  typedef struct packed {
    logic tag_we;
    logic age_we;
  } apr_wr_ctl_t;

endpackage

// ===== rtl/aging_page_replacement_core.sv =====
// Aging page replacement core: top level with the sequencer and the result register.
// Instantiates apr_frame_store; depends on apr_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready/in_page_number) takes one page reference
//   per word. The result channel (out_valid/out_ready and the out_ fields) returns
//   one word per reference: hit flag, frame holding the page, and the running hit
//   and miss totals including this reference.
//   The block works on one reference at a time. A tag scan reads one frame per
//   cycle through the frame store read port; a hit then reads and rewrites the
//   age of the matching frame (ST_HIT_RD, ST_HIT_WR). A miss runs a second pass
//   over the managed frames that finds the oldest frame and shifts every age,
//   then writes the new page. in_ready is high only while the block is idle.
//   The result register lets the next reference in while a result waits; a
//   stalled receiver then holds the following result in the sequencer.
//   cfg_wr_en/cfg_wr_data set frames_in_use; write it only while idle. Reset
//   clears ages, fill count and totals, sets 16 frames.
module aging_page_replacement_core
  import apr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] in_page_number,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [FRM_OUT_W-1:0] out_frame_index,
  output logic [TOTAL_W-1:0]   out_hit_total,
  output logic [TOTAL_W-1:0]   out_miss_total,
  // Configuration port.
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  apr_state_t state_r, state_nxt;

  logic [CFG_W-1:0]     cfg_frames_r;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                 q_vld_r, q_vld_nxt;
  logic [IDX_W-1:0]     q_idx_r, q_idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     frame_r, frame_nxt;
  logic [AGE_W-1:0]     best_age_r, best_age_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [TOTAL_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [TOTAL_W-1:0]   miss_cnt_r, miss_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [FRM_OUT_W-1:0] out_frame_r, out_frame_nxt;
  logic [TOTAL_W-1:0]   out_hit_tot_r, out_hit_tot_nxt;
  logic [TOTAL_W-1:0]   out_miss_tot_r, out_miss_tot_nxt;

  // Frame store connections.
  logic [IDX_W-1:0]     rd_idx;
  logic [PAGE_BITS-1:0] tag_q;
  logic [AGE_W-1:0]     age_q;
  apr_wr_ctl_t          wr_ctl;
  logic [IDX_W-1:0]     wr_idx;
  logic [AGE_W-1:0]     age_wdata;

  // Derived control terms.
  logic                 in_acc;
  logic                 slot_free;
  logic                 search_issue;
  logic                 scan_issue;
  logic                 tag_match;
  logic                 has_free;
  logic [NW-1:0]        cfg_ext;
  logic [NW-1:0]        frames_ext;
  logic [NW-1:0]        n_calc;
  logic [CNT_W-1:0]     n_acc;
  logic [IDX_W+FRM_OUT_W-1:0] frame_ext;

  assign in_acc       = in_valid && in_ready;
  assign slot_free    = !out_valid_r || out_ready;
  assign search_issue = rd_cnt_r < limit_r;
  assign scan_issue   = rd_cnt_r < n_r;
  assign tag_match    = q_vld_r && (tag_q == page_r);
  assign has_free     = filled_r < n_r;
  assign frame_ext    = {{FRM_OUT_W{1'b0}}, frame_r};

  // Managed frame count: zero acts as one, values above FRAMES act as FRAMES.
  assign cfg_ext    = NW'(cfg_frames_r);
  assign frames_ext = NW'(FRAMES);
  always_comb begin
    if (cfg_ext == '0) begin
      n_calc = NW'(1);
    end else if (cfg_ext > frames_ext) begin
      n_calc = frames_ext;
    end else begin
      n_calc = cfg_ext;
    end
  end
  assign n_acc = n_calc[CNT_W-1:0];

  apr_frame_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (rd_idx),
    .tag_q     (tag_q),
    .age_q     (age_q),
    .wr_ctl    (wr_ctl),
    .wr_idx    (wr_idx),
    .tag_wdata (page_r),
    .age_wdata (age_wdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tag_match) begin
          state_nxt = ST_HIT_RD;
        end else if (!q_vld_r && !search_issue) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_HIT_RD: state_nxt = ST_HIT_WR;
      ST_HIT_WR: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (!q_vld_r && !scan_issue) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: state_nxt = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, store read address and store writes.
  always_comb begin
    in_ready  = 1'b0;
    rd_idx    = rd_cnt_r[IDX_W-1:0];
    wr_ctl    = '0;
    wr_idx    = q_idx_r;
    age_wdata = age_q >> 1;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_HIT_RD: begin
        rd_idx = frame_r;
      end
      ST_HIT_WR: begin
        wr_ctl.age_we = 1'b1;
        wr_idx        = frame_r;
        age_wdata     = (age_q >> 1) | AGE_TOP;
      end
      ST_SCAN: begin
        // Every managed frame shifts; the new frame is overwritten afterwards.
        wr_ctl.age_we = q_vld_r;
        wr_idx        = q_idx_r;
        age_wdata     = age_q >> 1;
      end
      ST_FILL: begin
        wr_ctl.tag_we = 1'b1;
        wr_ctl.age_we = 1'b1;
        wr_idx        = frame_r;
        age_wdata     = has_free ? AGE_NEW : AGE_FULL;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    page_nxt         = page_r;
    n_nxt            = n_r;
    limit_nxt        = limit_r;
    filled_nxt       = filled_r;
    rd_cnt_nxt       = rd_cnt_r;
    q_vld_nxt        = 1'b0;
    q_idx_nxt        = q_idx_r;
    hit_nxt          = hit_r;
    frame_nxt        = frame_r;
    best_age_nxt     = best_age_r;
    best_idx_nxt     = best_idx_r;
    hit_cnt_nxt      = hit_cnt_r;
    miss_cnt_nxt     = miss_cnt_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_hit_nxt      = out_hit_r;
    out_frame_nxt    = out_frame_r;
    out_hit_tot_nxt  = out_hit_tot_r;
    out_miss_tot_nxt = out_miss_tot_r;
    case (state_r)
      ST_IDLE: begin
        // Latch the word and the search bounds.
        if (in_acc) begin
          page_nxt   = in_page_number;
          n_nxt      = n_acc;
          limit_nxt  = (filled_r < n_acc) ? filled_r : n_acc;
          rd_cnt_nxt = '0;
        end
      end
      ST_SEARCH: begin
        // One tag read per cycle; the compare uses the registered read data.
        q_vld_nxt = search_issue;
        q_idx_nxt = rd_cnt_r[IDX_W-1:0];
        if (search_issue) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
        if (tag_match) begin
          hit_nxt   = 1'b1;
          frame_nxt = q_idx_r;
        end else if (!q_vld_r && !search_issue) begin
          hit_nxt    = 1'b0;
          rd_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        // Oldest-frame search over the original ages; lowest index wins a tie.
        q_vld_nxt = scan_issue;
        q_idx_nxt = rd_cnt_r[IDX_W-1:0];
        if (scan_issue) begin
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
        if (q_vld_r && ((q_idx_r == '0) || (age_q < best_age_r))) begin
          best_age_nxt = age_q;
          best_idx_nxt = q_idx_r;
        end
        if (!q_vld_r && !scan_issue) begin
          frame_nxt = has_free ? filled_r[IDX_W-1:0] : best_idx_r;
        end
      end
      ST_FILL: begin
        if (has_free) begin
          filled_nxt = filled_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        // Count and publish once the result register is free.
        if (slot_free) begin
          hit_cnt_nxt      = hit_cnt_r + TOTAL_W'(hit_r);
          miss_cnt_nxt     = miss_cnt_r + TOTAL_W'(!hit_r);
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = hit_r;
          out_frame_nxt    = frame_ext[FRM_OUT_W-1:0];
          out_hit_tot_nxt  = hit_cnt_r + TOTAL_W'(hit_r);
          out_miss_tot_nxt = miss_cnt_r + TOTAL_W'(!hit_r);
        end
      end
      default: begin
        q_vld_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_frames_r <= CFG_FRAMES_RST;
      filled_r     <= '0;
      q_vld_r      <= 1'b0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        cfg_frames_r <= cfg_wr_data;
      end
      filled_r     <= filled_nxt;
      q_vld_r      <= q_vld_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    page_r         <= page_nxt;
    n_r            <= n_nxt;
    limit_r        <= limit_nxt;
    rd_cnt_r       <= rd_cnt_nxt;
    q_idx_r        <= q_idx_nxt;
    hit_r          <= hit_nxt;
    frame_r        <= frame_nxt;
    best_age_r     <= best_age_nxt;
    best_idx_r     <= best_idx_nxt;
    out_hit_r      <= out_hit_nxt;
    out_frame_r    <= out_frame_nxt;
    out_hit_tot_r  <= out_hit_tot_nxt;
    out_miss_tot_r <= out_miss_tot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame_index = out_frame_r;
  assign out_hit_total   = out_hit_tot_r;
  assign out_miss_total  = out_miss_tot_r;

`ifndef SYNTHESIS
  // The fill count never runs past the frame array.
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(FRAMES))
    else $error("fill count exceeds frame count");

  // The frame written on a miss is one of the managed frames.
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (CNT_W'(frame_r) < n_r))
    else $error("miss writes a frame outside the managed set");

  // Each published result bumps exactly one of the two totals.
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && slot_free) |=>
      (TOTAL_W'(hit_cnt_r + miss_cnt_r) ==
       TOTAL_W'($past(hit_cnt_r) + $past(miss_cnt_r) + TOTAL_W'(1))))
    else $error("hit and miss totals out of step");

  // A hit only comes out of the tag search.
  a_hit_source: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HIT_RD) |-> ($past(state_r) == ST_SEARCH))
    else $error("hit path entered without a search");
`endif

endmodule

// ===== rtl/apr_frame_store.sv =====
// Frame store: page tag memory and age memory with one read and one write port each.
// Ages read as zero until their entry is first written (valid bit per frame).
// Depends on apr_pkg.
module apr_frame_store
  import apr_pkg::*;
#(
  parameter int unsigned FRAMES    = FRAMES_DEF,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_idx,
  output logic [PAGE_BITS-1:0]                        tag_q,
  output logic [AGE_W-1:0]                            age_q,
  input  apr_wr_ctl_t                                 wr_ctl,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] wr_idx,
  input  logic [PAGE_BITS-1:0]                        tag_wdata,
  input  logic [AGE_W-1:0]                            age_wdata
);

  logic [PAGE_BITS-1:0] tag_mem [FRAMES];
  logic [AGE_W-1:0]     age_mem [FRAMES];
  logic [FRAMES-1:0]    age_vld_r;

  logic [PAGE_BITS-1:0] tag_q_r;
  logic [AGE_W-1:0]     age_q_r;
  logic                 age_vld_q_r;

  // Tag memory: registered read, single write.
  always_ff @(posedge clk) begin
    if (wr_ctl.tag_we) begin
      tag_mem[wr_idx] <= tag_wdata;
    end
    tag_q_r <= tag_mem[rd_idx];
  end

  // Age memory: registered read, single write.
  always_ff @(posedge clk) begin
    if (wr_ctl.age_we) begin
      age_mem[wr_idx] <= age_wdata;
    end
    age_q_r <= age_mem[rd_idx];
  end

  // Valid bits stand in for the all-zero reset of the ages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_vld_r   <= '0;
      age_vld_q_r <= 1'b0;
    end else begin
      if (wr_ctl.age_we) begin
        age_vld_r[wr_idx] <= 1'b1;
      end
      age_vld_q_r <= age_vld_r[rd_idx];
    end
  end

  assign tag_q = tag_q_r;
  assign age_q = age_vld_q_r ? age_q_r : '0;

endmodule
